[hdl/swr_pkg.sv]
package swr_pkg;

   // receive window in sequence numbers, 2 to 64
   localparam int RECV_WINDOW = 64;

   localparam int SEQ_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int SLOT_COUNT = 64;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(RECV_WINDOW);

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq_num;
      logic [BYTE_W-1:0] data_byte;
      logic              segment_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [SEQ_W-1:0]  out_seq;
      logic              last_of_run;
   } rsp_payload_type;

   // commands to the valid mark array
   typedef struct packed {
      logic     set_en;
      slot_type set_slot;
      logic     clr_en;
      slot_type clr_slot;
   } mark_cmd_type;

   // lookup result at the drain pointer
   typedef struct packed {
      logic cur_valid;
      logic next_valid;
   } mark_status_type;

endpackage

[hdl/swr_store.sv]
module swr_store
   import swr_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  slot_type          wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  slot_type          rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [SLOT_COUNT];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/swr_marks.sv]
module swr_marks
   import swr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mark_cmd_type    cmd,
   input  slot_type        query_slot,
   output mark_status_type status
);

   logic [SLOT_COUNT-1:0] valid_ff;
   logic [SLOT_COUNT-1:0] valid_in;
   slot_type              next_slot;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_en) begin
         valid_in[cmd.clr_slot] = 1'b0;
      end
      if (cmd.set_en) begin
         valid_in[cmd.set_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot index wraps around the ring
   assign next_slot         = query_slot + SLOT_W'(1);
   assign status.cur_valid  = valid_ff[query_slot];
   assign status.next_valid = valid_ff[next_slot];

endmodule

[hdl/sliding_window_reassembly.sv]
// Receive reorder buffer for a byte stream with 16-bit sequence numbers.
// Requests arrive on req_valid/req_ready carrying seq_num, data_byte and
// segment_end. A byte whose number lies within RECV_WINDOW of the next
// expected number is written into a 64-entry byte RAM and its slot marked
// valid; any other byte is dropped. The csr_write_en/csr_write_data port
// sets sink_ready. A segment-end request with sink_ready set starts a drain
// that walks the contiguous run of valid slots from the next expected
// number and sends each byte on rsp_valid/rsp_ready with its sequence
// number; last_of_run marks the final byte of the run.
// A request that causes no drain leaves the block ready for the next one.
// Each drained byte takes a mark lookup and RAM read in ST_LOOK, then an
// output register load in ST_FETCH, as the single RAM read port requires;
// an empty next expected slot ends the drain in ST_LOOK.
// No request is taken while a drain runs. When the receiver stalls, the
// output register holds its byte and the drain waits on it.
// Reset clears all valid marks, the next expected number and sink_ready at
// once; the byte RAM is not cleared.
module sliding_window_reassembly
   import swr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_en,
   input  logic            csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_FETCH
   } state_type;

   state_type       state_ff, state_in;
   logic [SEQ_W-1:0] next_exp_ff, next_exp_in;
   logic [SEQ_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            last_ff, last_in;
   logic            sink_ready_ff, sink_ready_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [SEQ_W-1:0]  offset;
   logic              in_win;
   logic              rsp_free;
   mark_cmd_type      mark_cmd;
   mark_status_type   mark_status;
   logic [BYTE_W-1:0] rd_data;
   logic              rd_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign offset    = req_data.seq_num - next_exp_ff;
   assign in_win    = offset < SEQ_W'(RECV_WINDOW);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rd_en     = (state_ff == ST_LOOK) && mark_status.cur_valid;

   assign mark_cmd.set_en   = accept && in_win;
   assign mark_cmd.set_slot = req_data.seq_num[SLOT_W-1:0];
   assign mark_cmd.clr_en   = rd_en;
   assign mark_cmd.clr_slot = cur_ff[SLOT_W-1:0];

   swr_marks u_marks (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mark_cmd),
      .query_slot (cur_ff[SLOT_W-1:0]),
      .status     (mark_status)
   );

   swr_store u_store (
      .clock   (clock),
      .wr_en   (mark_cmd.set_en),
      .wr_addr (mark_cmd.set_slot),
      .wr_data (req_data.data_byte),
      .rd_en   (rd_en),
      .rd_addr (cur_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      next_exp_in   = next_exp_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      sink_ready_in = csr_write_en ? csr_write_data : sink_ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.segment_end && sink_ready_ff) begin
               cur_in   = next_exp_ff;
               count_in = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (mark_status.cur_valid) begin
               // run ends at a gap or when the whole window is delivered
               last_in  = (count_ff == CNT_W'(RECV_WINDOW - 1)) ||
                          !mark_status.next_valid;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_byte    = rd_data;
               rsp_data_in.out_seq     = cur_ff;
               rsp_data_in.last_of_run = last_ff;
               cur_in                  = cur_ff + SEQ_W'(1);
               count_in                = count_ff + CNT_W'(1);
               if (last_ff) begin
                  next_exp_in = cur_ff + SEQ_W'(1);
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_exp_ff   <= '0;
         sink_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_exp_ff   <= next_exp_in;
         sink_ready_ff <= sink_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
